// File: rtl/assert_macros.svh
// Assertion macros for the checker file of the orientation quantiser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define VOQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Concurrent assertion that is also checked while reset is asserted.
`define VOQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: rtl/voq_pkg.sv
// Shared types, constants and the facing table of the vector orientation quantiser.
package voq_pkg;

    localparam int COORD_WIDTH = 16;
    // Magnitude of a delta; |src - dst| never exceeds 2**COORD_WIDTH - 1.
    localparam int MAG_W = COORD_WIDTH;
    localparam int SQ_W = 2 * MAG_W;
    // Sum of two squares, padded to an even width for the two-bit root steps.
    localparam int SUM_W = 2 * MAG_W + 2;
    localparam int ROOT_W = SUM_W / 2;

    localparam int DIST_HALVE_ABOVE = 3;

    // Queue between the front and back parts; the depth must be a power of two.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // Most transactions that can be held inside the block at once:
    // front register, queue, square and sum stages, root stages, divisor stage
    // and output register.
    localparam int CAPACITY = 1 + FIFO_DEPTH + 2 + ROOT_W + 2;
    localparam int PEND_W = $clog2(CAPACITY + 1) + 1;

    localparam int TABLE_COLS = 5;
    localparam int TABLE_SIZE = TABLE_COLS * TABLE_COLS;
    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int QIDX_W = 3;
    localparam logic [QIDX_W-1:0] QIDX_CENTRE = 3'd2;

    localparam logic [3:0] FACING_TABLE [TABLE_SIZE] = '{
        4'd6, 4'd7, 4'd8, 4'd9,  4'd10,
        4'd5, 4'd6, 4'd8, 4'd10, 4'd11,
        4'd4, 4'd4, 4'd0, 4'd12, 4'd12,
        4'd3, 4'd2, 4'd0, 4'd14, 4'd13,
        4'd2, 4'd1, 4'd0, 4'd15, 4'd14
    };

    // One classified item as it travels through the queue.
    typedef struct packed {
        logic [MAG_W-1:0] mag_x;
        logic [MAG_W-1:0] mag_y;
        logic             neg_x;
        logic             neg_y;
    } voq_entry_t;

    function automatic logic [3:0] facing_lookup(input logic [IDX_W-1:0] idx);
        logic [3:0] code;
        if (idx < IDX_W'(TABLE_SIZE))
            code = FACING_TABLE[idx];
        else
            code = '0;
        return code;
    endfunction

endpackage

// File: rtl/voq_front.sv
// Front part: takes point pairs and reduces them to delta magnitudes and signs.
module voq_front
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [voq_pkg::COORD_WIDTH-1:0] src_x,
    input  logic signed [voq_pkg::COORD_WIDTH-1:0] src_y,
    input  logic signed [voq_pkg::COORD_WIDTH-1:0] dst_x,
    input  logic signed [voq_pkg::COORD_WIDTH-1:0] dst_y,
    output logic                                   push_valid,
    input  logic                                   push_ready,
    output voq_pkg::voq_entry_t                    push_entry
);
    import voq_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    voq_entry_t       entry_reg;
    voq_entry_t       entry_next;
    logic [MAG_W:0]   dx;
    logic [MAG_W:0]   dy;
    logic             take;

    assign in_ready = !valid_reg || push_ready;
    assign take = in_valid && in_ready;

    always_comb
    begin
        dx = {src_x[COORD_WIDTH-1], src_x} - {dst_x[COORD_WIDTH-1], dst_x};
        dy = {src_y[COORD_WIDTH-1], src_y} - {dst_y[COORD_WIDTH-1], dst_y};
        entry_next.neg_x = dx[MAG_W];
        entry_next.neg_y = dy[MAG_W];
        entry_next.mag_x = dx[MAG_W] ? MAG_W'(-dx) : MAG_W'(dx);
        entry_next.mag_y = dy[MAG_W] ? MAG_W'(-dy) : MAG_W'(dy);
        if (take)
            valid_next = 1'b1;
        else if (push_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            entry_reg <= entry_next;
    end

    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

endmodule

// File: rtl/voq_fifo.sv
// Short register queue that decouples the front part from the back part.
module voq_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  voq_pkg::voq_entry_t push_entry,
    output logic                pop_valid,
    input  logic                pop_ready,
    output voq_pkg::voq_entry_t pop_entry
);
    import voq_pkg::*;

    voq_entry_t       mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(FIFO_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign push = push_valid && push_ready;
    assign pop = pop_valid && pop_ready;
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// File: rtl/voq_back.sv
// Back part: squares, integer square root, divisor, quotients and table lookup.
module voq_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  voq_pkg::voq_entry_t pop_entry,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [3:0]          orientation
);
    import voq_pkg::*;

    typedef struct packed {
        logic [ROOT_W:0]   rem;
        logic [ROOT_W-1:0] root;
        logic [SUM_W-1:0]  rad;
        logic [MAG_W-1:0]  mag_x;
        logic [MAG_W-1:0]  mag_y;
        logic              neg_x;
        logic              neg_y;
    } sq_stage_t;

    logic adv;

    // Square stage.
    logic             s1_valid_reg;
    logic [SQ_W-1:0]  s1_sqx_reg;
    logic [SQ_W-1:0]  s1_sqy_reg;
    voq_entry_t       s1_entry_reg;

    // Sum stage.
    logic             s2_valid_reg;
    logic [SUM_W-1:0] s2_sum_reg;
    voq_entry_t       s2_entry_reg;

    // Root stages, one result bit each.
    logic [ROOT_W-1:0] sq_valid_reg;
    logic [ROOT_W-1:0] sq_valid_next;
    sq_stage_t         sq_reg [ROOT_W];
    sq_stage_t         sq_next [ROOT_W];

    // Divisor stage.
    logic              dv_valid_reg;
    logic              dv_zero_reg;
    logic [ROOT_W-1:0] dv_div_reg;
    logic [MAG_W-1:0]  dv_mag_x_reg;
    logic [MAG_W-1:0]  dv_mag_y_reg;
    logic              dv_neg_x_reg;
    logic              dv_neg_y_reg;
    logic [ROOT_W-1:0] div_next;

    // Output register.
    logic              out_valid_reg;
    logic [3:0]        orientation_reg;
    logic [3:0]        orientation_next;

    logic [ROOT_W:0]   twice_div;
    logic [1:0]        qx_mag;
    logic [1:0]        qy_mag;
    logic [QIDX_W-1:0] col;
    logic [QIDX_W-1:0] row;
    logic [IDX_W-1:0]  idx;

    // The whole pipe moves whenever the output register can take a value.
    assign adv = !out_valid_reg || out_ready;
    assign pop_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sq_valid_reg <= '0;
            dv_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= pop_valid;
            s2_valid_reg <= s1_valid_reg;
            sq_valid_reg <= sq_valid_next;
            dv_valid_reg <= sq_valid_reg[ROOT_W-1];
            out_valid_reg <= dv_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sqx_reg <= SQ_W'(pop_entry.mag_x) * SQ_W'(pop_entry.mag_x);
            s1_sqy_reg <= SQ_W'(pop_entry.mag_y) * SQ_W'(pop_entry.mag_y);
            s1_entry_reg <= pop_entry;
            s2_sum_reg <= SUM_W'(s1_sqx_reg) + SUM_W'(s1_sqy_reg);
            s2_entry_reg <= s1_entry_reg;
        end
    end

    // Digit-by-digit root: each stage brings in two radicand bits.
    always_comb
    begin
        sq_stage_t          src;
        logic [ROOT_W+2:0]  rem_sh;
        logic [ROOT_W+2:0]  trial;
        sq_valid_next = {sq_valid_reg[ROOT_W-2:0], s2_valid_reg};
        for (int k = 0; k < ROOT_W; k++)
        begin
            if (k == 0)
            begin
                src.rem = '0;
                src.root = '0;
                src.rad = s2_sum_reg;
                src.mag_x = s2_entry_reg.mag_x;
                src.mag_y = s2_entry_reg.mag_y;
                src.neg_x = s2_entry_reg.neg_x;
                src.neg_y = s2_entry_reg.neg_y;
            end
            else
            begin
                src = sq_reg[k-1];
            end
            rem_sh = {src.rem, src.rad[SUM_W-1 -: 2]};
            trial = (ROOT_W+3)'({src.root, 2'b01});
            sq_next[k] = src;
            sq_next[k].rad = {src.rad[SUM_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                sq_next[k].rem = (ROOT_W+1)'(rem_sh - trial);
                sq_next[k].root = {src.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_next[k].rem = (ROOT_W+1)'(rem_sh);
                sq_next[k].root = {src.root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < ROOT_W; k++)
                sq_reg[k] <= sq_next[k];
        end
    end

    always_comb
    begin
        if (sq_reg[ROOT_W-1].root > ROOT_W'(DIST_HALVE_ABOVE))
            div_next = sq_reg[ROOT_W-1].root >> 1;
        else
            div_next = sq_reg[ROOT_W-1].root;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_zero_reg <= (sq_reg[ROOT_W-1].root == '0);
            dv_div_reg <= div_next;
            dv_mag_x_reg <= sq_reg[ROOT_W-1].mag_x;
            dv_mag_y_reg <= sq_reg[ROOT_W-1].mag_y;
            dv_neg_x_reg <= sq_reg[ROOT_W-1].neg_x;
            dv_neg_y_reg <= sq_reg[ROOT_W-1].neg_y;
        end
    end

    // Quotients are known to lie in 0..2 in magnitude, so two compares settle them.
    always_comb
    begin
        twice_div = {dv_div_reg, 1'b0};
        if ((ROOT_W+1)'(dv_mag_x_reg) >= twice_div)
            qx_mag = 2'd2;
        else if (ROOT_W'(dv_mag_x_reg) >= dv_div_reg)
            qx_mag = 2'd1;
        else
            qx_mag = 2'd0;
        if ((ROOT_W+1)'(dv_mag_y_reg) >= twice_div)
            qy_mag = 2'd2;
        else if (ROOT_W'(dv_mag_y_reg) >= dv_div_reg)
            qy_mag = 2'd1;
        else
            qy_mag = 2'd0;
        col = dv_neg_x_reg ? QIDX_CENTRE - QIDX_W'(qx_mag) : QIDX_CENTRE + QIDX_W'(qx_mag);
        row = dv_neg_y_reg ? QIDX_CENTRE - QIDX_W'(qy_mag) : QIDX_CENTRE + QIDX_W'(qy_mag);
        idx = IDX_W'(row) * IDX_W'(TABLE_COLS) + IDX_W'(col);
        orientation_next = dv_zero_reg ? 4'd0 : facing_lookup(idx);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            orientation_reg <= orientation_next;
    end

    assign out_valid = out_valid_reg;
    assign orientation = orientation_reg;

endmodule

// File: rtl/vector_orientation_quantizer.sv
// Top level of the vector orientation quantiser: front part, queue and back part.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+-----------------------------------------
//  in      | in_valid / in_ready | src_x, src_y, dst_x, dst_y (signed)
//  out     | out_valid/out_ready | orientation (4-bit facing code)
//
// One transaction is accepted per cycle while the queue has room, and one result
// leaves per cycle while the output is not stalled. Most of the path through the
// block is the square-root pipeline, which settles one root bit per stage.
// Reset is asynchronous and active low; it empties the queue and all stages.
// A stall on the output freezes the back part while the front part keeps
// accepting until the queue is full.
module vector_orientation_quantizer
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [voq_pkg::COORD_WIDTH-1:0] src_x,
    input  logic signed [voq_pkg::COORD_WIDTH-1:0] src_y,
    input  logic signed [voq_pkg::COORD_WIDTH-1:0] dst_x,
    input  logic signed [voq_pkg::COORD_WIDTH-1:0] dst_y,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [3:0]                             orientation
);
    import voq_pkg::*;

    // Front to queue.
    logic       push_valid;
    logic       push_ready;
    voq_entry_t push_entry;

    // Queue to back.
    logic       pop_valid;
    logic       pop_ready;
    voq_entry_t pop_entry;

    // The front part forms the deltas and splits each into sign and magnitude,
    // so the back part only ever works on unsigned values.
    voq_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .src_x      (src_x),
        .src_y      (src_y),
        .dst_x      (dst_x),
        .dst_y      (dst_y),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // The queue absorbs the transactions in flight when the output stalls.
    voq_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // The back part computes the distance, halves it above three, derives
    // the truncated quotients by comparison and reads the facing table.
    voq_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_entry   (pop_entry),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .orientation (orientation)
    );

endmodule

// File: rtl/voq_checker.sv
// Port-level checker for the vector orientation quantiser, with its bind.
`include "assert_macros.svh"

module voq_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] orientation
);
    import voq_pkg::*;

    logic [PEND_W-1:0] pending_reg;
    logic [PEND_W-1:0] pending_next;
    logic              in_take;
    logic              out_take;

    assign in_take = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    // Transactions accepted but not yet delivered.
    always_comb
    begin
        pending_next = pending_reg;
        if (in_take && !out_take)
            pending_next = pending_reg + PEND_W'(1);
        else if (!in_take && out_take)
            pending_next = pending_reg - PEND_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // The reset check looks at the next edge, so the first edge, before reset has
    // cleared the output register, is never sampled.
    `VOQ_ASSERT(a_no_invented_result, clk, rst_n, out_valid |-> (pending_reg != '0), "result shown with no transaction outstanding")
    `VOQ_ASSERT(a_capacity, clk, rst_n, pending_reg <= PEND_W'(CAPACITY), "more transactions held than the block can store")
    `VOQ_ASSERT(a_out_held, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(orientation)), "stalled result dropped or changed")
    `VOQ_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result shown during reset")

endmodule

bind vector_orientation_quantizer voq_checker u_voq_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .orientation (orientation)
);

// File: tb/tb_vector_orientation_quantizer.sv
// Self-checking testbench for the vector orientation quantiser, with a stalling sender and receiver.
`timescale 1ns / 100ps

module tb_vector_orientation_quantizer;

    import voq_pkg::*;

    // One point pair as it waits to be offered to the block.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] sx;
        logic signed [COORD_WIDTH-1:0] sy;
        logic signed [COORD_WIDTH-1:0] tx;
        logic signed [COORD_WIDTH-1:0] ty;
    } point_pair_t;

    localparam int CLK_HALF = 5;
    localparam int RESET_CYCLES = 9;
    // The tail wait leaves ample margin over the time the pipeline takes to answer.
    localparam int TAIL_CYCLES = 4 * (COORD_WIDTH + 6);
    // Long receiver stall, well beyond the number of transactions the block can hold.
    localparam int LONG_STALL = 300;
    localparam int CYCLE_LIMIT = 200000;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic signed [COORD_WIDTH-1:0] src_x = '0;
    logic signed [COORD_WIDTH-1:0] src_y = '0;
    logic signed [COORD_WIDTH-1:0] dst_x = '0;
    logic signed [COORD_WIDTH-1:0] dst_y = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [3:0]                    orientation;

    // Point pairs still to be offered, and facing codes still to be returned.
    point_pair_t pair_backlog[$];
    logic [3:0]  facing_expected[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_requests = 0;
    int stalls_served = 0;
    int stall_left = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    vector_orientation_quantizer dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .src_x       (src_x),
        .src_y       (src_y),
        .dst_x       (dst_x),
        .dst_y       (dst_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .orientation (orientation)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Expected facing code for one point pair. The deltas are taken at 64 bits so
    // that nothing wraps, the distance is the floor square root of the squared
    // length, and distances above the halving threshold are halved before they are
    // used as the divisor. Division in SystemVerilog truncates toward zero, which
    // is what the block is meant to do.
    function automatic logic [3:0] facing_code(input logic signed [COORD_WIDTH-1:0] sx,
                                               input logic signed [COORD_WIDTH-1:0] sy,
                                               input logic signed [COORD_WIDTH-1:0] tx,
                                               input logic signed [COORD_WIDTH-1:0] ty);
        longint dx;
        longint dy;
        longint len_sq;
        longint root_len;
        longint trial;
        longint qx;
        longint qy;
        int     b;
        int     idx;
        dx = longint'(sx) - longint'(tx);
        dy = longint'(sy) - longint'(ty);
        len_sq = dx * dx + dy * dy;
        // Bit-by-bit square root; the root of the largest sum stays below 2**18.
        root_len = 0;
        for (b = COORD_WIDTH + 1; b >= 0; b--)
        begin
            trial = root_len | (longint'(1) << b);
            if (trial * trial <= len_sq)
                root_len = trial;
        end
        if (root_len == 0)
            return 4'd0;
        if (root_len > DIST_HALVE_ABOVE)
            root_len = root_len >>> 1;
        qx = dx / root_len;
        qy = dy / root_len;
        // The quotients cannot leave -2..2, but the table index is guarded anyway.
        if (qx < -2) qx = -2;
        if (qx > 2)  qx = 2;
        if (qy < -2) qy = -2;
        if (qy > 2)  qy = 2;
        idx = int'((qy + 2) * TABLE_COLS + (qx + 2));
        return FACING_TABLE[idx];
    endfunction

    task automatic queue_pair(input int sx, input int sy, input int tx, input int ty);
        point_pair_t p;
        p.sx = COORD_WIDTH'(sx);
        p.sy = COORD_WIDTH'(sy);
        p.tx = COORD_WIDTH'(tx);
        p.ty = COORD_WIDTH'(ty);
        pair_backlog.push_back(p);
    endtask

    // Random point pairs of several flavours: fully random coordinates reach every
    // bit, short deltas of random scale sweep the whole facing table, and a few
    // coincident or extreme pairs keep the corner cases coming.
    task automatic queue_random(input int count);
        int n;
        int kind;
        int bx;
        int by;
        int span;
        int extremes[4];
        extremes = '{-32768, -1, 0, 32767};
        for (n = 0; n < count; n++)
        begin
            kind = $urandom_range(9);
            bx = int'($urandom);
            by = int'($urandom);
            if (kind < 3)
            begin
                queue_pair(bx, by, int'($urandom), int'($urandom));
            end
            else if (kind < 8)
            begin
                span = (1 << $urandom_range(COORD_WIDTH - 1)) - 1;
                if (span < 4)
                    span = 4;
                queue_pair(bx, by,
                           bx - span + int'($urandom_range(2 * span)),
                           by - span + int'($urandom_range(2 * span)));
            end
            else if (kind == 8)
            begin
                queue_pair(bx, by, bx, by);
            end
            else
            begin
                queue_pair(extremes[$urandom_range(3)], extremes[$urandom_range(3)],
                           extremes[$urandom_range(3)], extremes[$urandom_range(3)]);
            end
        end
    endtask

    // Waits until every queued pair has been taken by the block. Checked on the
    // falling edge, when the driver's updates of the rising edge have settled.
    task automatic wait_all_offered();
        @(negedge clk);
        while (pair_backlog.size() != 0 || in_valid)
            @(negedge clk);
    endtask

    // Waits until every taken pair has had its facing code returned.
    task automatic wait_all_returned();
        wait_all_offered();
        while (facing_expected.size() != 0)
            @(negedge clk);
    endtask

    // Driver: offers the next point pair from the backlog, holds it steady while the
    // block is not ready, and records the expected code when the transaction goes in.
    always @(posedge clk or negedge rst_n)
    begin : pair_driver
        point_pair_t next_pair;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                facing_expected.push_back(facing_code(src_x, src_y, dst_x, dst_y));
            if (!in_valid || in_ready)
            begin
                if (pair_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_pair = pair_backlog.pop_front();
                    src_x    <= next_pair.sx;
                    src_y    <= next_pair.sy;
                    dst_x    <= next_pair.tx;
                    dst_y    <= next_pair.ty;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each returned code against the oldest expectation and drives
    // the receiver's back-pressure, including the long stall when one is requested.
    always @(posedge clk or negedge rst_n)
    begin : facing_monitor
        logic [3:0] want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (facing_expected.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected orientation transaction, actual %0d",
                             $time, orientation);
                end
                else
                begin
                    want = facing_expected.pop_front();
                    if (orientation !== want)
                    begin
                        mismatch_count++;
                        $display("%0t: orientation mismatch, expected %0d, actual %0d",
                                 $time, want, orientation);
                    end
                end
            end
            if (stalls_served != stall_requests)
            begin
                stalls_served++;
                stall_left = LONG_STALL;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: a run that takes this long has hung somewhere.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL vector_orientation_quantizer");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed pairs: coincident points, unit steps in every direction, deltas
        // large enough to halve the distance and reach the outer table entries, and
        // the widest possible deltas in both signs.
        queue_pair(0, 0, 0, 0);
        queue_pair(-32768, 32767, -32768, 32767);
        queue_pair(1, 0, 0, 0);
        queue_pair(0, 0, 1, 0);
        queue_pair(0, 1, 0, 0);
        queue_pair(0, 0, 0, 1);
        queue_pair(1, 1, 0, 0);
        queue_pair(0, 0, 1, 1);
        queue_pair(1, 0, 0, 1);
        queue_pair(0, 1, 1, 0);
        queue_pair(2, 0, 0, 0);
        queue_pair(3, 3, 0, 0);
        queue_pair(4, 0, 0, 0);
        queue_pair(0, 0, 4, 0);
        queue_pair(0, 4, 0, 0);
        queue_pair(4, 4, 0, 0);
        queue_pair(0, 0, 4, 4);
        queue_pair(4, -4, 0, 0);
        queue_pair(32767, 0, -32768, 0);
        queue_pair(-32768, 0, 32767, 0);
        queue_pair(0, 32767, 0, -32768);
        queue_pair(32767, 32767, -32768, -32768);
        queue_pair(-32768, -32768, 32767, 32767);
        queue_pair(32767, -32768, -32768, 32767);
        wait_all_returned();

        // Sender idles less than the receiver.
        send_idle_pct = 23;
        recv_idle_pct = 48;
        queue_random(450);
        wait_all_offered();

        // The receiver holds off for a long stretch while the sender keeps offering,
        // so the queue fills and the input stalls; then the sender pauses until
        // every code has come back.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_requests++;
        queue_random(60);
        wait_all_returned();

        // Receiver idles less than the sender.
        send_idle_pct = 48;
        recv_idle_pct = 23;
        queue_random(450);
        wait_all_offered();

        // Neither side idles: back-to-back transactions.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(390);
        wait_all_returned();

        // Any stray result would show up within the pipeline latency.
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("PASS vector_orientation_quantizer");
        else
            $display("FAIL vector_orientation_quantizer");
        $finish;
    end

endmodule

// File: vector_orientation_quantizer.f
+incdir+rtl
rtl/voq_pkg.sv
rtl/voq_front.sv
rtl/voq_fifo.sv
rtl/voq_back.sv
rtl/vector_orientation_quantizer.sv
rtl/voq_checker.sv
tb/tb_vector_orientation_quantizer.sv
